// File: rtl/arpc_pkg.sv
// Package for the ARP cache: field widths, register indexes, the entry layout,
// the command and status types shared by the controller and datapath, and the controller state type.
// No dependencies.
package arpc_pkg;

  localparam int IP_W       = 32;
  localparam int MAC_W      = 48;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] TTL_RESET = 32'd600;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_KNOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL         = 2'd2;

  localparam logic FUNC_LEARN  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] tstamp;
    logic              vld;
  } entry_t;

  typedef enum logic [2:0] {
    RES_MISS,
    RES_HIT,
    RES_REFRESH,
    RES_ANNOUNCE,
    RES_LOCAL
  } res_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic      load;
    logic      issue;
    logic      clear_wr;
    logic      refresh_wr;
    logic      fill_wr;
    logic      set_res;
    res_kind_t res;
    logic      publish;
  } cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic is_local;
    logic data_vld;
    logic ip_match;
    logic fresh;
    logic issue_done;
  } status_t;

endpackage

// File: rtl/arpc_if.sv
// Handshake interfaces for the item channel into the ARP cache and the result
// channel out of it. Depends on arpc_pkg.
interface arpc_in_if import arpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [IP_W-1:0]   ip_address;
  logic [MAC_W-1:0]  mac_address;
  logic [TIME_W-1:0] now_seconds;

  modport source (output valid, func, ip_address, mac_address, now_seconds, input ready);
  modport sink (input valid, func, ip_address, mac_address, now_seconds, output ready);
endinterface

interface arpc_out_if import arpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [MAC_W-1:0] found_mac;
  logic             announce;
  logic             ignored_local;

  modport source (output valid, hit, found_mac, announce, ignored_local, input ready);
  modport sink (input valid, hit, found_mac, announce, ignored_local, output ready);
endinterface

// File: rtl/arpc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/arpc_ctrl.sv
// Controller for the ARP cache: sequences the table scan, the write-back and
// the result handoff. Depends on arpc_pkg.
module arpc_ctrl import arpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!status.is_lookup && status.is_local) begin
          cmd.set_res = 1'b1;
          cmd.res     = RES_LOCAL;
          state_nxt   = ST_RESULT;
        end else if (status.data_vld && status.ip_match) begin
          if (status.is_lookup) begin
            if (status.fresh) begin
              cmd.set_res = 1'b1;
              cmd.res     = RES_HIT;
              state_nxt   = ST_RESULT;
            end else begin
              cmd.clear_wr = 1'b1;
              cmd.issue    = 1'b1;
            end
          end else begin
            cmd.refresh_wr = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res        = RES_REFRESH;
            state_nxt      = ST_RESULT;
          end
        end else if (status.data_vld || !status.issue_done) begin
          cmd.issue = 1'b1;
        end else if (status.is_lookup) begin
          cmd.set_res = 1'b1;
          cmd.res     = RES_MISS;
          state_nxt   = ST_RESULT;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        cmd.set_res = 1'b1;
        cmd.res     = RES_ANNOUNCE;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/arpc_dp.sv
// Datapath for the ARP cache: configuration registers, item latch, entry table,
// scan pointer, victim trackers and result registers. Depends on arpc_pkg, arpc_ram.
module arpc_dp import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_func,
  input  logic [IP_W-1:0]       in_ip,
  input  logic [MAC_W-1:0]      in_mac,
  input  logic [TIME_W-1:0]     in_now,
  output logic                  out_hit,
  output logic [MAC_W-1:0]      out_mac,
  output logic                  out_announce,
  output logic                  out_ignored
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam int ENT_W = $bits(entry_t);

  logic              item_func_r;
  logic [IP_W-1:0]   item_ip_r;
  logic [MAC_W-1:0]  item_mac_r;
  logic [TIME_W-1:0] item_now_r;

  logic [IP_W-1:0]   local_ip_r;
  logic              local_known_r;
  logic [TIME_W-1:0] ttl_r;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  issue_idx_r;
  logic              pend_r;
  logic [IDX_W-1:0]  pend_idx_r;

  logic              cand_vld_r;
  logic [IDX_W-1:0]  cand_idx_r;
  logic              old_vld_r;
  logic [IDX_W-1:0]  old_idx_r;
  logic [TIME_W-1:0] old_age_r;

  logic              res_hit_r;
  logic [MAC_W-1:0]  res_mac_r;
  logic              res_announce_r;
  logic              res_ignored_r;
  logic              out_hit_r;
  logic [MAC_W-1:0]  out_mac_r;
  logic              out_announce_r;
  logic              out_ignored_r;

  entry_t            rd_entry;
  entry_t            new_entry;
  entry_t            wr_entry;
  logic [ENT_W-1:0]  rd_bits;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  fill_addr;
  logic [TIME_W-1:0] age;
  logic              fresh;
  logic              full;
  logic              issue_go;

  arpc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (issue_idx_r[IDX_W-1:0]),
    .rdata (rd_bits)
  );

  assign rd_entry = entry_t'(rd_bits);
  assign age      = item_now_r - rd_entry.tstamp;
  assign fresh    = (age <= ttl_r);
  assign full     = (count_r == CNT_W'(CACHE_ENTRIES));
  assign issue_go = cmd.issue && (issue_idx_r != count_r);

  assign new_entry.ip     = item_ip_r;
  assign new_entry.mac    = item_mac_r;
  assign new_entry.tstamp = item_now_r;
  assign new_entry.vld    = 1'b1;

  always_comb begin
    if (cand_vld_r) begin
      fill_addr = cand_idx_r;
    end else if (!full) begin
      fill_addr = count_r[IDX_W-1:0];
    end else begin
      fill_addr = old_idx_r;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_idx_r;
    wr_entry  = new_entry;
    if (cmd.clear_wr) begin
      ram_we       = 1'b1;
      wr_entry     = rd_entry;
      wr_entry.vld = 1'b0;
    end else if (cmd.refresh_wr) begin
      ram_we = 1'b1;
    end else if (cmd.fill_wr) begin
      ram_we    = 1'b1;
      ram_waddr = fill_addr;
    end
  end

  always_comb begin
    status.is_lookup  = (item_func_r == FUNC_LOOKUP);
    status.is_local   = local_known_r && (item_ip_r == local_ip_r);
    status.data_vld   = pend_r;
    status.ip_match   = rd_entry.vld && (rd_entry.ip == item_ip_r);
    status.fresh      = fresh;
    status.issue_done = (issue_idx_r == count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r    <= '0;
      local_known_r <= 1'b0;
      ttl_r         <= TTL_RESET;
      count_r       <= '0;
      issue_idx_r   <= '0;
      pend_r        <= 1'b0;
      cand_vld_r    <= 1'b0;
      old_vld_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOCAL_IP:    local_ip_r    <= cfg_wdata[IP_W-1:0];
          CFG_LOCAL_KNOWN: local_known_r <= cfg_wdata[0];
          CFG_TTL:         ttl_r         <= cfg_wdata[TIME_W-1:0];
          default: begin
          end
        endcase
      end

      if (cmd.load) begin
        item_func_r <= in_func;
        item_ip_r   <= in_ip;
        item_mac_r  <= in_mac;
        item_now_r  <= in_now;
        issue_idx_r <= '0;
        pend_r      <= 1'b0;
        cand_vld_r  <= 1'b0;
        old_vld_r   <= 1'b0;
      end else begin
        pend_r <= issue_go;
        if (issue_go) begin
          pend_idx_r  <= issue_idx_r[IDX_W-1:0];
          issue_idx_r <= issue_idx_r + CNT_W'(1);
        end
        if (pend_r) begin
          if ((!rd_entry.vld || !fresh) && !cand_vld_r) begin
            cand_vld_r <= 1'b1;
            cand_idx_r <= pend_idx_r;
          end
          if (!old_vld_r || (age > old_age_r)) begin
            old_vld_r <= 1'b1;
            old_idx_r <= pend_idx_r;
            old_age_r <= age;
          end
        end
      end

      if (cmd.fill_wr && !cand_vld_r && !full) begin
        count_r <= count_r + CNT_W'(1);
      end

      if (cmd.set_res) begin
        res_hit_r      <= 1'b0;
        res_mac_r      <= '0;
        res_announce_r <= 1'b0;
        res_ignored_r  <= 1'b0;
        case (cmd.res)
          RES_HIT: begin
            res_hit_r <= 1'b1;
            res_mac_r <= rd_entry.mac;
          end
          RES_ANNOUNCE: res_announce_r <= 1'b1;
          RES_LOCAL:    res_ignored_r  <= 1'b1;
          default: begin
          end
        endcase
      end

      if (cmd.publish) begin
        out_hit_r      <= res_hit_r;
        out_mac_r      <= res_mac_r;
        out_announce_r <= res_announce_r;
        out_ignored_r  <= res_ignored_r;
      end
    end
  end

  assign out_hit      = out_hit_r;
  assign out_mac      = out_mac_r;
  assign out_announce = out_announce_r;
  assign out_ignored  = out_ignored_r;

endmodule

// File: rtl/arp_cache_with_ttl_and_lru.sv
// Top level of the IPv4-to-MAC cache with aging and oldest-entry replacement.
// Depends on arpc_pkg, arpc_if, arpc_ram, arpc_ctrl and arpc_dp.
//
//   Port      Direction  Handshake         Carries
//   in_ch     sink       valid/ready       func, ip_address, mac_address, now_seconds
//   out_ch    source     valid/ready       hit, found_mac, announce, ignored_local
//   cfg_*     input      cfg_we only       cfg_index, cfg_wdata
//
// A scan reads the table through the single read port, which visits one entry per cycle;
// a learn that inserts adds a fill step after the scan. A fresh match, or any match for
// a learn, ends the scan early; a local learn is dropped without a scan, and on an empty
// table a lookup misses and a learn inserts without reading any entry.
// Reset clears the entry count and local address, sets the TTL to TTL_RESET; the table needs no clearing pass.
// A result waits in the output register while the next item is accepted and scanned.
module arp_cache_with_ttl_and_lru import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  arpc_in_if.sink               in_ch,
  arpc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  arpc_dp #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_func      (in_ch.func),
    .in_ip        (in_ch.ip_address),
    .in_mac       (in_ch.mac_address),
    .in_now       (in_ch.now_seconds),
    .out_hit      (out_ch.hit),
    .out_mac      (out_ch.found_mac),
    .out_announce (out_ch.announce),
    .out_ignored  (out_ch.ignored_local)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
